>>> hw/rtl/thick_line_pixel_coverage_top_defines.svh
// assertion macros used by the checker module tlpc_chk
`ifndef THICK_LINE_PIXEL_COVERAGE_TOP_DEFINES_SVH
`define THICK_LINE_PIXEL_COVERAGE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TLPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TLPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tlpc_pkg.sv
package tlpc_pkg;

  localparam int CoordW   = 16;
  localparam int ColorW   = 32;
  localparam int WidthW   = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int Depth    = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartX     = 3'd0,
    CfgStartY     = 3'd1,
    CfgEndX       = 3'd2,
    CfgEndY       = 3'd3,
    CfgLineColor  = 3'd4,
    CfgLineWidth  = 3'd5,
    CfgEmptyColor = 3'd6
  } tlpc_cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic [ColorW-1:0]        line_color;
    logic [WidthW-1:0]        line_width;
    logic [ColorW-1:0]        empty_color;
  } tlpc_cfg_t;

  typedef struct packed {
    logic in_box;
    logic axis;
    logic axis_cov;
  } tlpc_flags_t;

  typedef struct packed {
    logic signed [16:0] rx;
    logic signed [16:0] ry;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [15:0]        tsq;
    tlpc_flags_t        flags;
  } tlpc_geom_t;

  typedef struct packed {
    tlpc_flags_t flags;
    logic        big;
    logic        dot_ok;
    logic [63:0] adsq;
    logic [46:0] thr;
  } tlpc_dist_t;

  function automatic logic signed [33:0] smul17(logic signed [16:0] a,
                                                logic signed [16:0] b);
    logic signed [33:0] ax;
    logic signed [33:0] bx;
    ax = 34'(a);
    bx = 34'(b);
    return ax * bx;
  endfunction

endpackage

>>> hw/rtl/tlpc_cfg.sv
module tlpc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tlpc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [tlpc_pkg::CfgDataW-1:0]       cfg_data_i,
  output tlpc_pkg::tlpc_cfg_t                 cfg_o
);

  tlpc_pkg::tlpc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x     <= '0;
      cfg_q.start_y     <= '0;
      cfg_q.end_x       <= '0;
      cfg_q.end_y       <= '0;
      cfg_q.line_color  <= '0;
      cfg_q.line_width  <= tlpc_pkg::WidthW'(1);
      cfg_q.empty_color <= '0;
    end else if (cfg_we_i) begin
      unique case (tlpc_pkg::tlpc_cfg_idx_e'(cfg_idx_i))
        tlpc_pkg::CfgStartX:     cfg_q.start_x     <= cfg_data_i[tlpc_pkg::CoordW-1:0];
        tlpc_pkg::CfgStartY:     cfg_q.start_y     <= cfg_data_i[tlpc_pkg::CoordW-1:0];
        tlpc_pkg::CfgEndX:       cfg_q.end_x       <= cfg_data_i[tlpc_pkg::CoordW-1:0];
        tlpc_pkg::CfgEndY:       cfg_q.end_y       <= cfg_data_i[tlpc_pkg::CoordW-1:0];
        tlpc_pkg::CfgLineColor:  cfg_q.line_color  <= cfg_data_i[tlpc_pkg::ColorW-1:0];
        tlpc_pkg::CfgLineWidth:  cfg_q.line_width  <= cfg_data_i[tlpc_pkg::WidthW-1:0];
        tlpc_pkg::CfgEmptyColor: cfg_q.empty_color <= cfg_data_i[tlpc_pkg::ColorW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/tlpc_front.sv
module tlpc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tlpc_pkg::tlpc_cfg_t             cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [tlpc_pkg::CoordW-1:0] pixel_x_i,
  input  logic signed [tlpc_pkg::CoordW-1:0] pixel_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tlpc_pkg::tlpc_geom_t            geom_o
);

  logic signed [18:0] px, py, xs, ys, xe, ye, h, t;
  logic signed [18:0] dx, dy, rx, ry, adx, ady, arx, ary;
  logic signed [18:0] minx, maxx, miny, maxy, bx, by, hx, hy;
  logic               in_x, in_y, is_vert, is_horiz, vert_ok, horiz_ok;
  tlpc_pkg::tlpc_geom_t geom_d, geom_q;
  logic               valid_q;
  logic               rdy;

  always_comb begin
    px  = 19'(pixel_x_i);
    py  = 19'(pixel_y_i);
    xs  = 19'(cfg_i.start_x);
    ys  = 19'(cfg_i.start_y);
    xe  = 19'(cfg_i.end_x);
    ye  = 19'(cfg_i.end_y);
    t   = 19'(cfg_i.line_width);
    h   = 19'(cfg_i.line_width[tlpc_pkg::WidthW-1:1]);
    dx  = xe - xs;
    dy  = ye - ys;
    rx  = px - xs;
    ry  = py - ys;
    adx = dx[18] ? -dx : dx;
    ady = dy[18] ? -dy : dy;
    arx = rx[18] ? -rx : rx;
    ary = ry[18] ? -ry : ry;
    minx = (xs < xe) ? xs : xe;
    maxx = (xs < xe) ? xe : xs;
    miny = (ys < ye) ? ys : ye;
    maxy = (ys < ye) ? ye : ys;
    bx  = minx - h;
    by  = miny - h;
    hx  = bx + adx + t;
    hy  = by + ady + t;
    in_x = (px >= bx) && (px < hx);
    in_y = (py >= by) && (py < hy);
    is_vert  = (dx == '0);
    is_horiz = (dy == '0);
    vert_ok  = (arx <= h) && (py >= miny) && (py <= maxy);
    horiz_ok = (ary <= h) && (px >= minx) && (px <= maxx);

    geom_d.rx  = rx[16:0];
    geom_d.ry  = ry[16:0];
    geom_d.dx  = dx[16:0];
    geom_d.dy  = dy[16:0];
    geom_d.tsq = 16'(cfg_i.line_width) * 16'(cfg_i.line_width);
    geom_d.flags.in_box   = in_x && in_y;
    geom_d.flags.axis     = is_vert || is_horiz;
    geom_d.flags.axis_cov = in_x && in_y && (is_vert ? vert_ok : horiz_ok);
  end

  assign rdy        = !valid_q || out_ready_i;
  assign in_ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      geom_q <= geom_d;
    end
  end

  assign out_valid_o = valid_q;
  assign geom_o      = geom_q;

endmodule

>>> hw/rtl/tlpc_dist.sv
module tlpc_dist (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tlpc_pkg::tlpc_geom_t  geom_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tlpc_pkg::tlpc_dist_t  dist_o
);

  // products
  logic                  v2_q, rdy2;
  tlpc_pkg::tlpc_flags_t flags2_q;
  logic [15:0]           tsq2_q;
  logic signed [33:0]    p1_q, p2_q, q1_q, q2_q, sx_q, sy_q;

  // sums
  logic                  v3_q, rdy3;
  tlpc_pkg::tlpc_flags_t flags3_q;
  logic [15:0]           tsq3_q;
  logic signed [34:0]    d3_q, dot3_q;
  logic [32:0]           len3_q;

  // magnitude, bound product, segment test
  logic                  v4_q, rdy4;
  tlpc_pkg::tlpc_flags_t flags4_q;
  logic                  big4_q, dot_ok4_q;
  logic [31:0]           ad4_q;
  logic [48:0]           tl4_q;
  logic [34:0]           ad;

  // square and threshold
  logic                  v5_q, rdy5;
  tlpc_pkg::tlpc_dist_t  dist5_q;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= in_valid_i;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) begin
      flags2_q <= geom_i.flags;
      tsq2_q   <= geom_i.tsq;
      p1_q     <= tlpc_pkg::smul17(geom_i.dy, geom_i.rx);
      p2_q     <= tlpc_pkg::smul17(geom_i.dx, geom_i.ry);
      q1_q     <= tlpc_pkg::smul17(geom_i.rx, geom_i.dx);
      q2_q     <= tlpc_pkg::smul17(geom_i.ry, geom_i.dy);
      sx_q     <= tlpc_pkg::smul17(geom_i.dx, geom_i.dx);
      sy_q     <= tlpc_pkg::smul17(geom_i.dy, geom_i.dy);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      flags3_q <= flags2_q;
      tsq3_q   <= tsq2_q;
      d3_q     <= 35'(p1_q) - 35'(p2_q);
      dot3_q   <= 35'(q1_q) + 35'(q2_q);
      len3_q   <= {1'b0, sx_q[31:0]} + {1'b0, sy_q[31:0]};
    end
  end

  assign ad = d3_q[34] ? 35'(-d3_q) : 35'(d3_q);

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      flags4_q  <= flags3_q;
      big4_q    <= (ad[34:32] != 3'd0);
      ad4_q     <= ad[31:0];
      tl4_q     <= 49'(tsq3_q) * 49'(len3_q);
      dot_ok4_q <= !dot3_q[34] && (dot3_q[33:0] <= {1'b0, len3_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      dist5_q.flags  <= flags4_q;
      dist5_q.big    <= big4_q;
      dist5_q.dot_ok <= dot_ok4_q;
      dist5_q.adsq   <= 64'(ad4_q) * 64'(ad4_q);
      dist5_q.thr    <= tl4_q[48:2];
    end
  end

  assign out_valid_o = v5_q;
  assign dist_o      = dist5_q;

endmodule

>>> hw/rtl/thick_line_pixel_coverage_top.sv
// thick line pixel coverage: one pixel word in, one colour word out
// six register stages lie between s_axis accept and m_axis_tvalid
// throughput: one word per cycle unless stalled; multipliers fully pipelined
// a stall on m_axis_tready holds each occupied stage; nothing is dropped
// reset: rst_ni low empties the pipeline and loads register defaults (width 1)
module thick_line_pixel_coverage_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // pixel_x, pixel_y
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tlpc_pkg::ColorW-1:0]       m_axis_tdata,  // pixel_color
  output logic                              m_axis_tuser,  // covered
  input  logic                              cfg_we_i,
  input  logic [tlpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tlpc_pkg::CfgDataW-1:0]     cfg_data_i
);

  tlpc_pkg::tlpc_cfg_t  cfg;
  tlpc_pkg::tlpc_geom_t geom;
  tlpc_pkg::tlpc_dist_t dist_res;
  logic                 front_valid, front_ready;
  logic                 dist_valid, out_rdy;
  logic                 diag_ok, cov;
  logic                 m_valid_q;
  logic [tlpc_pkg::ColorW-1:0] m_data_q;
  logic                 m_user_q;

  tlpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tlpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pixel_x_i   (s_axis_tdata[15:0]),
    .pixel_y_i   (s_axis_tdata[31:16]),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .geom_o      (geom)
  );

  tlpc_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .geom_i      (geom),
    .out_valid_o (dist_valid),
    .out_ready_i (out_rdy),
    .dist_o      (dist_res)
  );

  assign diag_ok = !dist_res.big && (dist_res.adsq <= {17'd0, dist_res.thr}) &&
                   dist_res.dot_ok;
  assign cov     = dist_res.flags.axis ? dist_res.flags.axis_cov
                                       : (dist_res.flags.in_box && diag_ok);
  assign out_rdy = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_rdy) begin
      m_valid_q <= dist_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && dist_valid) begin
      m_data_q <= cov ? cfg.line_color : cfg.empty_color;
      m_user_q <= cov;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

>>> hw/rtl/tlpc_chk.sv
`include "thick_line_pixel_coverage_top_defines.svh"

module tlpc_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [tlpc_pkg::ColorW-1:0]       m_axis_tdata,
  input logic                              m_axis_tuser
);

  localparam int CntW = $clog2(tlpc_pkg::Depth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `TLPC_ASSERT_IMPL(a_ready_when_drained, (!m_axis_tvalid || m_axis_tready), s_axis_tready, "input stalled with output free")
  `TLPC_ASSERT_IMPL(a_no_phantom, m_axis_tvalid, (cnt_q != '0), "output word with nothing in flight")
  `TLPC_ASSERT_IMPL(a_depth, 1'b1, (cnt_q <= CntW'(tlpc_pkg::Depth)), "more words in flight than stages")
  `TLPC_ASSERT_NEXT(a_hold, (m_axis_tvalid && !m_axis_tready), (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled output word changed")

endmodule

bind thick_line_pixel_coverage_top tlpc_chk u_tlpc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
